>>> hw/rtl/mbwd_pkg.sv
// shared types and constants for the mixed base-w digit splitter
package mbwd_pkg;

    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 6;
    localparam int DIG_W      = 8;
    localparam int SUM_W      = 16;
    localparam int CNT_W      = 7;
    localparam int BITS_W     = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_SUM_BASE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SUM_RANGE = 2'd1;

    localparam logic [SUM_W-1:0] SUM_BASE_RST  = 16'h0000;
    localparam logic [SUM_W-1:0] SUM_RANGE_RST = 16'hFFFF;

    // digit results per input beat are capped at this count
    localparam logic [IDX_W-1:0] MAX_DIGIT_RESULTS = 6'd63;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_FLUSH,
        ST_SUM
    } t_state;

    typedef struct packed {
        logic              last;
        logic [BYTE_W-1:0] data;
    } t_beat;

    typedef struct packed {
        logic                  we;
        logic [CFG_ADDR_W-1:0] addr;
        logic [SUM_W-1:0]      data;
    } t_cfg_wr;

    typedef struct packed {
        logic             is_checksum;
        logic [IDX_W-1:0] chain_index;
        logic [DIG_W-1:0] digit_value;
        logic [SUM_W-1:0] checksum_length;
        logic             accepted;
        logic             end_of_run;
    } t_result;

endpackage

>>> hw/rtl/mixed_base_w_digits_checksum.sv
// top level of the mixed base-w digit splitter with checksum
//
//  channel   dir  handshake                        payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata byte, tlast last byte
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata digit/sum, tuser, tlast
//  cfg       in   i_cfg_valid/o_cfg_ready          addr register, data value
//
// a byte leaves the input queue in the idle state; the digit engine then
// completes one digit per cycle while m_axis does not stall, and takes a
// further step when bits are left over for the next digit or when every
// digit is already done. a last byte then flushes the remaining digits, one
// per cycle under the same condition, and ends with the checksum result.
// reset is synchronous, active low, clears run state and sets the sum window registers to their defaults.
// the four-beat input queue keeps taking bytes while results wait on m_axis.
module mixed_base_w_digits_checksum
    import mbwd_pkg::*;
#(
    parameter int DIGEST_BYTES = 32,
    parameter int LOG_W1       = 5,
    parameter int COUNT_W1     = 24,
    parameter int LOG_W2       = 4,
    parameter int COUNT_W2     = 34
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [BYTE_W-1:0]     i_s_axis_tdata,   // [7:0] data_byte
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [5:0] chain_index, [13:6] digit_value, [29:14] checksum_length,
    // [30] accepted, [31] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tuser,   // [0] is_checksum
    output logic                  o_m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [SUM_W-1:0]      i_cfg_data
);

    logic    head_valid;
    t_beat   head;
    logic    pop;
    t_cfg_wr cfg;
    t_result result;

    assign o_cfg_ready = 1'b1;
    assign cfg         = '{we: i_cfg_valid, addr: i_cfg_addr, data: i_cfg_data};

    mbwd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_pop           (pop),
        .o_head_valid    (head_valid),
        .o_head          (head)
    );

    mbwd_back #(
        .DIGEST_BYTES (DIGEST_BYTES),
        .LOG_W1       (LOG_W1),
        .COUNT_W1     (COUNT_W1),
        .LOG_W2       (LOG_W2),
        .COUNT_W2     (COUNT_W2)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_result     (result)
    );

    assign o_m_axis_tdata = {1'b0, result.accepted, result.checksum_length,
                             result.digit_value, result.chain_index};
    assign o_m_axis_tuser = result.is_checksum;
    assign o_m_axis_tlast = result.end_of_run;

endmodule

>>> hw/rtl/mbwd_front.sv
// input side: takes digest bytes and queues them for the digit engine
module mbwd_front
    import mbwd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [BYTE_W-1:0] i_s_axis_tdata,
    input  logic              i_s_axis_tlast,
    input  logic              i_pop,
    output logic              o_head_valid,
    output t_beat             o_head
);

    t_beat              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               push;
    logic               pop;

    assign o_s_axis_tready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_head_valid    = (r_count != '0);
    assign pop             = i_pop && o_head_valid;
    assign o_head          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{last: i_s_axis_tlast, data: i_s_axis_tdata};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hw/rtl/mbwd_back.sv
// digit engine: cuts queued bytes into digits, keeps the checksum, drives results
module mbwd_back
    import mbwd_pkg::*;
#(
    parameter int DIGEST_BYTES = 32,
    parameter int LOG_W1       = 5,
    parameter int COUNT_W1     = 24,
    parameter int LOG_W2       = 4,
    parameter int COUNT_W2     = 34
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_head_valid,
    input  t_beat   i_head,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int TOTAL    = COUNT_W1 + COUNT_W2;
    localparam int CONS_MAX = (8 * (TOTAL + 1) > 8 * DIGEST_BYTES) ?
                              8 * (TOTAL + 1) : 8 * DIGEST_BYTES;
    localparam int CONS_W   = $clog2(CONS_MAX + 1);

    localparam logic [CONS_W-1:0] DIGEST_BITS = CONS_W'(8 * DIGEST_BYTES);
    localparam logic [CNT_W:0]    TOTAL_C     = (CNT_W + 1)'(TOTAL);
    localparam logic [CNT_W:0]    COUNT_W1_C  = (CNT_W + 1)'(COUNT_W1);
    localparam logic [BITS_W-1:0] LOG_W1_C    = BITS_W'(LOG_W1);
    localparam logic [BITS_W-1:0] LOG_W2_C    = BITS_W'(LOG_W2);
    localparam logic [BITS_W-1:0] BYTE_BITS   = BITS_W'(BYTE_W);

    function automatic logic [BITS_W-1:0] width_of(input logic [CNT_W:0] idx);
        width_of = (idx < COUNT_W1_C) ? LOG_W1_C : LOG_W2_C;
    endfunction

    t_state             r_state, n_state;
    logic [BYTE_W-1:0]  r_byte, n_byte;
    logic [BITS_W-1:0]  r_pos, n_pos;
    logic               r_last, n_last;
    logic [DIG_W-1:0]   r_partial, n_partial;
    logic [BITS_W-1:0]  r_bits, n_bits;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [SUM_W-1:0]   r_acc, n_acc;
    logic [CONS_W-1:0]  r_consumed, n_consumed;
    logic [IDX_W-1:0]   r_nres, n_nres;
    logic [SUM_W-1:0]   r_base;
    logic [SUM_W-1:0]   r_range;
    logic               r_ovalid;
    t_result            r_out;

    logic [CNT_W:0]     cnt_ext;
    logic [CNT_W:0]     cnt_inc;
    logic               digits_left;
    logic [BITS_W-1:0]  w;
    logic [BITS_W-1:0]  need;
    logic [BITS_W-1:0]  avail;
    logic [BITS_W-1:0]  pos_fin;
    logic [DIG_W-1:0]   maxv;
    logic [DIG_W-1:0]   take_mask;
    logic [BYTE_W-1:0]  rem;
    logic [DIG_W-1:0]   dig_bits;
    logic [DIG_W-1:0]   dig_flush;
    logic               more;
    logic [SUM_W:0]     win_top;
    logic               sum_ok;
    logic               emit;
    logic               out_free;
    logic               go;
    t_result            res;

    assign cnt_ext     = {1'b0, r_cnt};
    assign cnt_inc     = cnt_ext + (CNT_W + 1)'(1);
    assign digits_left = (cnt_ext < TOTAL_C);
    assign w           = width_of(cnt_ext);
    assign need        = w - r_bits;
    assign avail       = BYTE_BITS - r_pos;
    assign pos_fin     = r_pos + need;
    assign maxv        = DIG_W'((9'd1 << w) - 9'd1);
    assign take_mask   = DIG_W'((9'd1 << need) - 9'd1);
    assign rem         = r_byte >> r_pos;
    assign dig_bits    = (r_partial | ((rem & take_mask) << r_bits)) & maxv;
    assign dig_flush   = r_partial & maxv;
    // another digit completes inside this byte after the current one
    assign more        = (cnt_inc < TOTAL_C) && ((BYTE_BITS - pos_fin) >= width_of(cnt_inc));
    assign win_top     = {1'b0, r_base} + {1'b0, r_range};
    assign sum_ok      = (r_acc >= r_base) && ({1'b0, r_acc} <= win_top);
    assign out_free    = !r_ovalid || i_ready;

    always_comb begin
        n_state    = r_state;
        n_byte     = r_byte;
        n_pos      = r_pos;
        n_last     = r_last;
        n_partial  = r_partial;
        n_bits     = r_bits;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_consumed = r_consumed;
        n_nres     = r_nres;
        o_pop      = 1'b0;
        emit       = 1'b0;
        res        = '0;
        go         = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    o_pop   = 1'b1;
                    // bits past the digest read as zero
                    n_byte  = (r_consumed >= DIGEST_BITS) ? '0 : i_head.data;
                    n_pos   = '0;
                    n_last  = i_head.last;
                    n_nres  = '0;
                    n_state = ST_BITS;
                end
            end
            ST_BITS: begin
                if (!digits_left) begin
                    n_state = r_last ? ST_FLUSH : ST_IDLE;
                end else if (avail >= need) begin
                    emit            = (r_nres != MAX_DIGIT_RESULTS);
                    res.chain_index = r_cnt[IDX_W-1:0];
                    res.digit_value = dig_bits;
                    res.end_of_run  = !r_last && !more;
                    go              = !emit || out_free;
                    if (go) begin
                        n_acc      = r_acc + SUM_W'(maxv - dig_bits);
                        n_cnt      = r_cnt + CNT_W'(1);
                        n_partial  = '0;
                        n_bits     = '0;
                        n_pos      = pos_fin;
                        n_consumed = r_consumed + CONS_W'(need);
                        if (emit) begin
                            n_nres = r_nres + IDX_W'(1);
                        end
                        if ((pos_fin == BYTE_BITS) || (cnt_inc >= TOTAL_C)) begin
                            n_state = r_last ? ST_FLUSH : ST_IDLE;
                        end
                    end
                end else begin
                    // byte runs out inside the digit: keep the bits for the next beat
                    n_partial  = r_partial | (rem << r_bits);
                    n_bits     = r_bits + avail;
                    n_consumed = r_consumed + CONS_W'(avail);
                    n_pos      = BYTE_BITS;
                    n_state    = r_last ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (!digits_left) begin
                    n_state = ST_SUM;
                end else begin
                    emit            = (r_nres != MAX_DIGIT_RESULTS);
                    res.chain_index = r_cnt[IDX_W-1:0];
                    res.digit_value = dig_flush;
                    go              = !emit || out_free;
                    if (go) begin
                        n_acc     = r_acc + SUM_W'(maxv - dig_flush);
                        n_cnt     = r_cnt + CNT_W'(1);
                        n_partial = '0;
                        n_bits    = '0;
                        if (emit) begin
                            n_nres = r_nres + IDX_W'(1);
                        end
                    end
                end
            end
            ST_SUM: begin
                emit                = 1'b1;
                res.is_checksum     = 1'b1;
                res.chain_index     = IDX_W'(TOTAL);
                res.checksum_length = sum_ok ? (r_acc - r_base) : '0;
                res.accepted        = sum_ok;
                res.end_of_run      = 1'b1;
                go                  = out_free;
                if (go) begin
                    n_partial  = '0;
                    n_bits     = '0;
                    n_cnt      = '0;
                    n_acc      = '0;
                    n_consumed = '0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_partial  <= '0;
            r_bits     <= '0;
            r_cnt      <= '0;
            r_acc      <= '0;
            r_consumed <= '0;
            r_nres     <= '0;
            r_last     <= 1'b0;
            r_pos      <= '0;
            r_ovalid   <= 1'b0;
            r_base     <= SUM_BASE_RST;
            r_range    <= SUM_RANGE_RST;
        end else begin
            r_state    <= n_state;
            r_partial  <= n_partial;
            r_bits     <= n_bits;
            r_cnt      <= n_cnt;
            r_acc      <= n_acc;
            r_consumed <= n_consumed;
            r_nres     <= n_nres;
            r_last     <= n_last;
            r_pos      <= n_pos;
            if (emit && go) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg.we) begin
                case (i_cfg.addr)
                    CFG_SUM_BASE:  r_base  <= i_cfg.data;
                    CFG_SUM_RANGE: r_range <= i_cfg.data;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (emit && go) begin
            r_out <= res;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_out;

endmodule

>>> verif/mixed_base_w_digits_checksum_test.sv
// self-checking stream testbench for the mixed base-w digit splitter with checksum
`timescale 1ns / 1ps

module mixed_base_w_digits_checksum_test;
    import mbwd_pkg::*;

    localparam int DIGEST_BYTES = 32;
    localparam int LOG_W1       = 5;
    localparam int COUNT_W1     = 24;
    localparam int LOG_W2       = 4;
    localparam int COUNT_W2     = 34;
    localparam int TOTAL_DIGITS = COUNT_W1 + COUNT_W2;

    localparam int IDLE_PCT      = 13;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRINT_CAP     = 30;

    // unused register slots, written to check they are ignored
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 2'd3;

    // run shapes
    localparam int RUN_FULL  = 0;
    localparam int RUN_EARLY = 1;
    localparam int RUN_PAST  = 2;
    localparam int RUN_NOISE = 3;

    // byte content
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZEROS  = 1;
    localparam int FILL_ONES   = 2;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  s_tvalid   = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata    = '0;
    logic                  s_tlast    = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready   = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
    logic [SUM_W-1:0]      cfg_data   = '0;

    mixed_base_w_digits_checksum #(
        .DIGEST_BYTES(DIGEST_BYTES),
        .LOG_W1      (LOG_W1),
        .COUNT_W1    (COUNT_W1),
        .LOG_W2      (LOG_W2),
        .COUNT_W2    (COUNT_W2)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .o_m_axis_tlast (m_tlast),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // splitter state and registers as the block should hold them
    logic [SUM_W-1:0]  sum_base  = SUM_BASE_RST;
    logic [SUM_W-1:0]  sum_range = SUM_RANGE_RST;
    logic [DIG_W-1:0]  part_digit = '0;
    logic [BITS_W-1:0] bits_open  = '0;
    logic [CNT_W-1:0]  digit_cnt  = '0;
    logic [SUM_W-1:0]  chk_acc    = '0;

    t_beat   bytes_to_send[$];
    t_result results_due[$];
    t_result held_r;
    bit      held_ok = 1'b0;
    int      step_count;

    int  bytes_queued   = 0;
    int  bytes_accepted = 0;
    int  mismatch_cnt   = 0;
    int  digit_beats    = 0;
    int  sum_beats      = 0;
    int  sum_accepts    = 0;
    int  cfg_writes     = 0;
    int  cycle_cnt      = 0;
    bit  byte_taken     = 1'b0;
    bit  quiet          = 1'b0;
    bit  hold_req       = 1'b0;
    int  hold_left      = 0;

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatch_cnt < PRINT_CAP)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    function automatic int digit_width(input logic [CNT_W-1:0] idx);
        return (idx < COUNT_W1) ? LOG_W1 : LOG_W2;
    endfunction

    // the last result of a step is held back so end_of_run can be set on it
    task automatic emit(input t_result r);
        if (held_ok)
            results_due.push_back(held_r);
        held_r  = r;
        held_ok = 1'b1;
    endtask

    task automatic close_digit();
        int      w;
        int      maxv;
        int      d;
        t_result r;
        w    = digit_width(digit_cnt);
        maxv = (1 << w) - 1;
        d    = part_digit & maxv;
        chk_acc = chk_acc + SUM_W'(maxv - d);
        if (step_count < MAX_DIGIT_RESULTS) begin
            r = '0;
            r.chain_index = digit_cnt[IDX_W-1:0];
            r.digit_value = DIG_W'(d);
            emit(r);
            step_count++;
        end
        digit_cnt  = digit_cnt + CNT_W'(1);
        part_digit = '0;
        bits_open  = '0;
    endtask

    task automatic split_byte(input logic [BYTE_W-1:0] data_in, input logic last_in);
        logic [BYTE_W-1:0] b;
        int                used;
        int                k;
        int                csum;
        bit                ok;
        t_result           r;
        b          = data_in;
        step_count = 0;
        if (digit_cnt < TOTAL_DIGITS) begin
            if (digit_cnt <= COUNT_W1)
                used = digit_cnt * LOG_W1;
            else
                used = COUNT_W1 * LOG_W1 + (digit_cnt - COUNT_W1) * LOG_W2;
            used += bits_open;
            // bits beyond the digest read as zero
            if ((used >> 3) >= DIGEST_BYTES)
                b = '0;
            for (k = 0; k < 8 && digit_cnt < TOTAL_DIGITS; k++) begin
                part_digit = part_digit | ({7'b0, b[k]} << bits_open);
                bits_open  = bits_open + BITS_W'(1);
                if (bits_open >= digit_width(digit_cnt))
                    close_digit();
            end
        end
        if (last_in) begin
            while (digit_cnt < TOTAL_DIGITS)
                close_digit();
            csum = chk_acc;
            ok   = (csum >= int'(sum_base)) && (csum <= int'(sum_base) + int'(sum_range));
            r = '0;
            r.is_checksum     = 1'b1;
            r.chain_index     = IDX_W'(TOTAL_DIGITS);
            r.accepted        = ok;
            r.checksum_length = ok ? SUM_W'(csum - int'(sum_base)) : '0;
            emit(r);
            part_digit = '0;
            bits_open  = '0;
            digit_cnt  = '0;
            chk_acc    = '0;
        end
        if (held_ok) begin
            held_r.end_of_run = 1'b1;
            results_due.push_back(held_r);
            held_ok = 1'b0;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (results_due.size() == 0) begin
            flag_mismatch("result beat with nothing due", int'(m_tdata), -1);
            return;
        end
        want = results_due.pop_front();
        if (m_tuser != want.is_checksum)
            flag_mismatch("is_checksum", m_tuser, want.is_checksum);
        if (m_tdata[5:0] != want.chain_index)
            flag_mismatch("chain_index", m_tdata[5:0], want.chain_index);
        if (m_tdata[13:6] != want.digit_value)
            flag_mismatch("digit_value", m_tdata[13:6], want.digit_value);
        if (m_tdata[29:14] != want.checksum_length)
            flag_mismatch("checksum_length", m_tdata[29:14], want.checksum_length);
        if (m_tdata[30] != want.accepted)
            flag_mismatch("accepted", m_tdata[30], want.accepted);
        if (m_tdata[31] != 1'b0)
            flag_mismatch("tdata pad bit", m_tdata[31], 0);
        if (m_tlast != want.end_of_run)
            flag_mismatch("end_of_run", m_tlast, want.end_of_run);
        if (want.is_checksum) begin
            sum_beats++;
            if (want.accepted)
                sum_accepts++;
        end else begin
            digit_beats++;
        end
    endtask

    // input beats are predicted before output beats are checked in the same edge
    always @(posedge i_clk) begin
        byte_taken = 1'b0;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                byte_taken = 1'b1;
                bytes_accepted++;
                split_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
                check_result();
        end
    end

    // byte driver: holds a beat until it is taken
    always @(negedge i_clk) begin : drive_bytes
        t_beat nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || byte_taken) begin
            if (bytes_to_send.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = bytes_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.data;
                s_tlast  <= nxt.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic push_byte(input logic [BYTE_W-1:0] data, input logic last);
        t_beat bt;
        bt.data = data;
        bt.last = last;
        bytes_to_send.push_back(bt);
        bytes_queued++;
    endtask

    task automatic queue_run(input int shape, input int fill, output int len);
        int                i;
        logic [BYTE_W-1:0] data;
        logic              last;
        case (shape)
            RUN_FULL:  len = DIGEST_BYTES;
            RUN_EARLY: len = $urandom_range(DIGEST_BYTES - 1, 1);
            RUN_PAST:  len = DIGEST_BYTES + $urandom_range(4, 1);
            default:   len = $urandom_range(12, 1);
        endcase
        for (i = 0; i < len; i++) begin
            case (fill)
                FILL_ZEROS: data = 8'h00;
                FILL_ONES:  data = 8'hFF;
                default:    data = BYTE_W'($urandom);
            endcase
            if (shape == RUN_NOISE)
                last = ($urandom_range(7) == 0);
            else
                last = (i == len - 1);
            push_byte(data, last);
        end
    endtask

    task automatic queue_random_runs(input int budget);
        int got;
        int len;
        int pick;
        int shape;
        int fill;
        got = 0;
        while (got < budget) begin
            pick = $urandom_range(99);
            if (pick < 55)      shape = RUN_FULL;
            else if (pick < 75) shape = RUN_EARLY;
            else if (pick < 88) shape = RUN_PAST;
            else                shape = RUN_NOISE;
            pick = $urandom_range(99);
            if (pick < 80)      fill = FILL_RANDOM;
            else if (pick < 90) fill = FILL_ZEROS;
            else                fill = FILL_ONES;
            queue_run(shape, fill, len);
            got += len;
        end
    endtask

    // waits until every queued byte is taken and every due result is in, then lets the block settle
    task automatic drain();
        @(negedge i_clk);
        while (bytes_accepted != bytes_queued || results_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [SUM_W-1:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        if (addr == CFG_SUM_BASE)
            sum_base = value;
        else if (addr == CFG_SUM_RANGE)
            sum_range = value;
        cfg_writes++;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int len;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset window: early last on the very first byte, short runs, split digits
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'h3C, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h0F, 1'b0);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b1);
        queue_random_runs(12);
        drain();

        // only a zero checksum passes: all-ones digest gives exactly that
        write_reg(CFG_SUM_BASE, 16'h0000);
        write_reg(CFG_SUM_RANGE, 16'h0000);
        queue_run(RUN_FULL, FILL_ONES, len);
        queue_random_runs(40 - len);
        drain();

        // window beyond any reachable sum; spare slots must not disturb it
        write_reg(CFG_SUM_BASE, 16'hFFFF);
        write_reg(CFG_SUM_RANGE, 16'hFFFF);
        write_reg(CFG_SPARE_A, 16'($urandom));
        write_reg(CFG_SPARE_B, 16'($urandom));
        queue_random_runs(12);
        drain();

        // window around the typical sum, with the receiver holding off so input backs up
        write_reg(CFG_SUM_BASE, 16'($urandom_range(700, 500)));
        write_reg(CFG_SUM_RANGE, 16'($urandom_range(200, 0)));
        queue_random_runs(12);
        hold_req = 1'b1;
        drain();

        // wide-open window, both sides running without gaps
        write_reg(CFG_SUM_BASE, 16'h0000);
        write_reg(CFG_SUM_RANGE, 16'hFFFF);
        quiet = 1'b1;
        queue_random_runs(40);
        drain();
        quiet = 1'b0;

        // all-zero digest hits the largest sum exactly at the window edge
        write_reg(CFG_SUM_BASE, 16'(LOG_W1 > 0 ? COUNT_W1 * ((1 << LOG_W1) - 1)
                                                + COUNT_W2 * ((1 << LOG_W2) - 1) : 0));
        write_reg(CFG_SUM_RANGE, 16'h0000);
        queue_run(RUN_FULL, FILL_ZEROS, len);
        queue_random_runs(40 - len);
        drain();

        write_reg(CFG_SUM_BASE, 16'($urandom_range(1254, 0)));
        write_reg(CFG_SUM_RANGE, 16'($urandom));
        queue_random_runs(12);
        drain();

        if (results_due.size() != 0)
            flag_mismatch("results never delivered", 0, results_due.size());
        $display("run covered %0d bytes, %0d digit beats, %0d checksum beats (%0d in window)",
                 bytes_accepted, digit_beats, sum_beats, sum_accepts);
        $display("%0d register writes, %0d mismatches", cfg_writes, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
